### rtl/dtq_pkg.sv
// Shared types, constants and helpers of the delayed task queue.
package dtq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TIME_W   = 64;

  // Action codes.
  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_SUBMIT    = 3'd1;
  localparam logic [2:0] ACT_DISPATCH  = 3'd2;
  localparam logic [2:0] ACT_TERMINATE = 3'd3;
  localparam logic [2:0] ACT_STOP      = 3'd4;
  localparam logic [2:0] ACT_REOPEN    = 3'd5;

  // Status codes.
  localparam logic [2:0] ST_ACCEPTED   = 3'd0;
  localparam logic [2:0] ST_REJ_TERM   = 3'd1;
  localparam logic [2:0] ST_REJ_FULL   = 3'd2;
  localparam logic [2:0] ST_DISPATCHED = 3'd3;
  localparam logic [2:0] ST_NONE_DUE   = 3'd4;
  localparam logic [2:0] ST_RAN_IMM    = 3'd5;
  localparam logic [2:0] ST_DONE       = 3'd6;

  // Queue modes.
  localparam logic [2:0] MODE_THREAD_POOL = 3'd1;
  localparam logic [2:0] MODE_MANUAL      = 3'd3;
  localparam logic [2:0] MODE_IMMEDIATE   = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] task_tag;
    logic [31:0] delay;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_tag;
    logic        canceled;
    logic [4:0]  pending;
  } out_item_t;

  typedef struct packed {
    logic [15:0]       tag;
    logic [TIME_W-1:0] due;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_run;
    logic commit;
  } dtq_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_free;
  } dtq_stat_t;

  // Ring slot at a given offset from the head, wrapped at the capacity.
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### rtl/dtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/dtq_ctrl.sv
// Controller state machine sequencing accept, execute, scan and commit.
module dtq_ctrl
  import dtq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dtq_stat_t stat,
  output dtq_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.need_scan) state_next = S_SCAN;
        else if (stat.out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        if (stat.need_scan) cmd.scan_start = 1'b1;
        else cmd.commit = stat.out_free;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
      end
      S_FINISH: begin
        cmd.commit = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

### rtl/dtq_datapath.sv
// Queue state, task RAM, due-time scan and the output register.
module dtq_datapath
  import dtq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dtq_cmd_t   cmd,
  output dtq_stat_t  stat,
  input  in_item_t   in_item,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  // Architectural state.
  logic [2:0]        queue_mode;
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  held;
  logic [TIME_W-1:0] time_now;
  logic              term;
  logic              canc;

  // Current item.
  in_item_t          item;

  // Scan state.
  logic [CNT_W-1:0]  rd_off;
  logic [CNT_W-1:0]  cmp_off;
  logic              cmp_valid;
  entry_t            head_ent;
  logic              found;
  logic [CNT_W-1:0]  hit_off;
  logic [15:0]       hit_tag;

  // RAM port signals.
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_ent;
  entry_t              new_ent;
  logic                hit;

  // Commit values.
  logic [IDX_W-1:0]  head_next;
  logic [CNT_W-1:0]  held_next;
  logic [TIME_W-1:0] time_now_next;
  logic              term_next;
  logic              canc_next;
  out_item_t         result;

  dtq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_ent    = entry_t'(ram_rdata);
  assign ram_raddr = slot_add(head, rd_off);
  assign hit       = term || (rd_ent.due <= time_now);

  assign new_ent.tag = item.task_tag;
  assign new_ent.due = time_now + TIME_W'(item.delay);

  assign stat.need_scan = (item.action == ACT_DISPATCH) && (held != '0);
  assign stat.scan_done = cmp_valid && (hit || (cmp_off == held - CNT_W'(1)));
  assign stat.out_free  = !out_valid || out_ready;

  always_comb begin
    head_next     = head;
    held_next     = held;
    time_now_next = time_now;
    term_next     = term;
    canc_next     = canc;
    ram_we        = 1'b0;
    ram_waddr     = slot_add(head, held);
    ram_wdata     = ENTRY_W'(new_ent);
    result        = '0;
    result.status = ST_ACCEPTED;
    case (item.action)
      ACT_TICK: begin
        time_now_next = time_now + TIME_W'(1);
      end
      ACT_SUBMIT: begin
        if (queue_mode == MODE_IMMEDIATE) begin
          result.status  = ST_RAN_IMM;
          result.out_tag = item.task_tag;
        end else if (term) begin
          result.status = ST_REJ_TERM;
        end else if (held == CNT_W'(CAPACITY)) begin
          result.status = ST_REJ_FULL;
        end else begin
          ram_we    = cmd.commit;
          held_next = held + CNT_W'(1);
        end
      end
      ACT_DISPATCH: begin
        if (found && held != '0) begin
          result.status   = ST_DISPATCHED;
          result.out_tag  = hit_tag;
          result.canceled = canc;
          head_next       = slot_add(head, CNT_W'(1));
          held_next       = held - CNT_W'(1);
          // The due entry moves out; the old head takes its slot.
          if (hit_off != '0) begin
            ram_we    = cmd.commit;
            ram_waddr = slot_add(head, hit_off);
            ram_wdata = ENTRY_W'(head_ent);
          end
        end else begin
          result.status = term ? ST_DONE : ST_NONE_DUE;
        end
      end
      ACT_TERMINATE: begin
        term_next = 1'b1;
        if (queue_mode != MODE_MANUAL) canc_next = 1'b1;
      end
      ACT_STOP: begin
        term_next = 1'b1;
        canc_next = 1'b1;
      end
      ACT_REOPEN: begin
        head_next = '0;
        held_next = '0;
        term_next = 1'b0;
        canc_next = 1'b0;
      end
      default: ;
    endcase
    result.pending = 5'(held_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_mode <= MODE_THREAD_POOL;
      head       <= '0;
      held       <= '0;
      time_now   <= '0;
      term       <= 1'b0;
      canc       <= 1'b0;
      out_valid  <= 1'b0;
      cmp_valid  <= 1'b0;
      found      <= 1'b0;
      rd_off     <= '0;
    end else begin
      if (cfg_we) queue_mode <= cfg_wdata;

      if (cmd.load) found <= 1'b0;

      if (cmd.scan_start) begin
        rd_off    <= '0;
        cmp_valid <= 1'b0;
      end

      // One RAM read per cycle; the compare sees the registered entry addressed in the previous cycle.
      if (cmd.scan_run) begin
        rd_off    <= rd_off + CNT_W'(1);
        cmp_off   <= rd_off;
        cmp_valid <= 1'b1;
        if (cmp_valid) begin
          if (cmp_off == '0) head_ent <= rd_ent;
          if (hit) begin
            found   <= 1'b1;
            hit_off <= cmp_off;
            hit_tag <= rd_ent.tag;
          end
        end
      end

      if (cmd.commit) begin
        head      <= head_next;
        held      <= held_next;
        time_now  <= time_now_next;
        term      <= term_next;
        canc      <= canc_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_item;
    if (cmd.commit) out_item <= result;
  end

endmodule

### rtl/delayed_task_queue.sv
// Top level of the delayed task queue: controller and datapath.
//
//   Channel   Direction  Handshake              Beat payload
//   in        input      in_valid / in_ready    in_item  (action, task_tag, delay)
//   out       output     out_valid / out_ready  out_item (status, out_tag, canceled, pending)
//   cfg       input      cfg_we                 cfg_wdata (queue_mode)
//
// Each input beat gives exactly one output beat. Most actions commit their result from
// the execute state that follows acceptance, once the output is free, and the next
// beat is then taken in the idle state. A dispatch with tasks held first scans the task
// RAM from the head, one entry per cycle, until it reads a due task or the last held one.
// One item is in work at a time; the output register lets the next item be
// accepted while a result waits, and a commit waits while the output is full.
// Synchronous reset clears the queue, time and flags and sets queue_mode to 1.
module delayed_task_queue
  import dtq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata
);

  dtq_cmd_t  cmd;
  dtq_stat_t stat;

  dtq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  dtq_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

### rtl/dtq_checker.sv
// Port-level checks on the delayed task queue, bound to the top level.
module dtq_checker
  import dtq_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("output payload changed while stalled");

  // The queue never reports more tasks than it can hold.
  a_pending_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.pending <= 5'(CAPACITY))
    else $error("pending exceeds capacity");

  // Only a dispatch or an immediate run carries a tag or a canceled flag.
  a_tag_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_DISPATCHED && out_item.status != ST_RAN_IMM
    |-> out_item.out_tag == 16'd0 && !out_item.canceled)
    else $error("tag or canceled set on a non-running result");

  // Reset leaves no result on offer.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind delayed_task_queue dtq_checker u_dtq_checker (.*);
